[hdl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and helper functions of the Euler angle to
// quaternion core: CORDIC word formats and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

  localparam int Q_BITS       = 32;
  localparam int PROD_BITS    = 2 * Q_BITS;
  localparam int ATAN_ENTRIES = 30;
  localparam int LANES        = 3;

  // inverse CORDIC gain in Q30
  localparam logic signed [Q_BITS-1:0] INV_GAIN = 32'sd652032874;

  // one CORDIC lane: cosine, sine and residual phase
  typedef struct packed {
    logic signed [Q_BITS-1:0] x;
    logic signed [Q_BITS-1:0] y;
    logic signed [Q_BITS-1:0] z;
  } rot_t;

  // lanes: 0 yaw, 1 pitch, 2 roll
  typedef rot_t [LANES-1:0] rot3_t;

  // roll trig and the four pitch/yaw pair products, all Q30
  typedef struct packed {
    logic signed [Q_BITS-1:0] cr;
    logic signed [Q_BITS-1:0] sr;
    logic signed [Q_BITS-1:0] pc;
    logic signed [Q_BITS-1:0] ps;
    logic signed [Q_BITS-1:0] pcs;
    logic signed [Q_BITS-1:0] psc;
  } mix_t;

  // atan(2^-i) in phase units, 2^31 = pi
  function automatic logic signed [Q_BITS-1:0] atan_phase(input logic [4:0] idx);
    unique case (idx)
      5'd0:    atan_phase = 32'sh20000000;
      5'd1:    atan_phase = 32'sh12E4051E;
      5'd2:    atan_phase = 32'sh09FB385B;
      5'd3:    atan_phase = 32'sh051111D4;
      5'd4:    atan_phase = 32'sh028B0D43;
      5'd5:    atan_phase = 32'sh0145D7E1;
      5'd6:    atan_phase = 32'sh00A2F61E;
      5'd7:    atan_phase = 32'sh00517C55;
      5'd8:    atan_phase = 32'sh0028BE53;
      5'd9:    atan_phase = 32'sh00145F2F;
      5'd10:   atan_phase = 32'sh000A2F98;
      5'd11:   atan_phase = 32'sh000517CC;
      5'd12:   atan_phase = 32'sh00028BE6;
      5'd13:   atan_phase = 32'sh000145F3;
      5'd14:   atan_phase = 32'sh0000A2FA;
      5'd15:   atan_phase = 32'sh0000517D;
      5'd16:   atan_phase = 32'sh000028BE;
      5'd17:   atan_phase = 32'sh0000145F;
      5'd18:   atan_phase = 32'sh00000A30;
      5'd19:   atan_phase = 32'sh00000518;
      5'd20:   atan_phase = 32'sh0000028C;
      5'd21:   atan_phase = 32'sh00000146;
      5'd22:   atan_phase = 32'sh000000A3;
      5'd23:   atan_phase = 32'sh00000051;
      5'd24:   atan_phase = 32'sh00000029;
      5'd25:   atan_phase = 32'sh00000014;
      5'd26:   atan_phase = 32'sh0000000A;
      5'd27:   atan_phase = 32'sh00000005;
      5'd28:   atan_phase = 32'sh00000003;
      5'd29:   atan_phase = 32'sh00000001;
      default: atan_phase = '0;
    endcase
  endfunction

  // Q60 product rounded to Q30, ties toward plus infinity
  function automatic logic signed [Q_BITS-1:0] round_q30(input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] t;
    t = p + (PROD_BITS'(1) << 29);
    round_q30 = t[61:30];
  endfunction

endpackage

`default_nettype wire

[hdl/e2q_in_if.sv]
// ----------------------------------------------------------------------------
// e2q_in_if
// Request channel carrying yaw, pitch and roll binary angles.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2q_in_if #(
  parameter int ANGLE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;

  modport source (output valid, output yaw_angle, output pitch_angle,
                  output roll_angle, input ready);
  modport sink   (input valid, input yaw_angle, input pitch_angle,
                  input roll_angle, output ready);
endinterface

`default_nettype wire

[hdl/e2q_out_if.sv]
// ----------------------------------------------------------------------------
// e2q_out_if
// Result channel carrying one unit quaternion per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2q_out_if #(
  parameter int FRAC_BITS = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] quat_w;
  logic signed [FRAC_BITS+1:0] quat_x;
  logic signed [FRAC_BITS+1:0] quat_y;
  logic signed [FRAC_BITS+1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

`default_nettype wire

[hdl/e2q_cell.sv]
// ----------------------------------------------------------------------------
// e2q_cell
// One CORDIC rotation stage for the three angle lanes, with its own
// register slot and valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  e2q_pkg::rot3_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output e2q_pkg::rot3_t dn_data
);

  logic                               valid_r;
  e2q_pkg::rot3_t                     data_r;
  e2q_pkg::rot3_t                     data_nxt;
  logic signed [e2q_pkg::Q_BITS-1:0]  atan_c;

  assign atan_c   = e2q_pkg::atan_phase(5'(STAGE));
  assign up_ready = !valid_r || dn_ready;

  for (genvar k = 0; k < e2q_pkg::LANES; k++) begin : g_lane
    logic signed [e2q_pkg::Q_BITS-1:0] dx;
    logic signed [e2q_pkg::Q_BITS-1:0] dy;

    assign dx = $signed(up_data[k].y) >>> STAGE;
    assign dy = $signed(up_data[k].x) >>> STAGE;

    always_comb begin
      if (!up_data[k].z[e2q_pkg::Q_BITS-1]) begin
        data_nxt[k].x = up_data[k].x - dx;
        data_nxt[k].y = up_data[k].y + dy;
        data_nxt[k].z = up_data[k].z - atan_c;
      end else begin
        data_nxt[k].x = up_data[k].x + dx;
        data_nxt[k].y = up_data[k].y - dy;
        data_nxt[k].z = up_data[k].z + atan_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

[hdl/e2q_pair.sv]
// ----------------------------------------------------------------------------
// e2q_pair
// Pitch/yaw pair products rounded to Q30; roll cosine and sine ride along.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_pair (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  e2q_pkg::rot3_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output e2q_pkg::mix_t  dn_data
);

  logic                               valid_r;
  e2q_pkg::mix_t                      data_r;
  e2q_pkg::mix_t                      data_nxt;
  logic signed [e2q_pkg::Q_BITS-1:0]  cy, sy, cp, sp;

  assign cy = up_data[0].x;
  assign sy = up_data[0].y;
  assign cp = up_data[1].x;
  assign sp = up_data[1].y;

  always_comb begin
    data_nxt.cr  = up_data[2].x;
    data_nxt.sr  = up_data[2].y;
    data_nxt.pc  = e2q_pkg::round_q30(cp * cy);
    data_nxt.ps  = e2q_pkg::round_q30(sp * sy);
    data_nxt.pcs = e2q_pkg::round_q30(cp * sy);
    data_nxt.psc = e2q_pkg::round_q30(sp * cy);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

[hdl/e2q_quat.sv]
// ----------------------------------------------------------------------------
// e2q_quat
// Roll products, then sum, round and saturate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_quat #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  e2q_pkg::mix_t               up_data,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic signed [FRAC_BITS+1:0] dn_w,
  output logic signed [FRAC_BITS+1:0] dn_x,
  output logic signed [FRAC_BITS+1:0] dn_y,
  output logic signed [FRAC_BITS+1:0] dn_z
);

  localparam int PW = e2q_pkg::PROD_BITS;
  localparam int RW = FRAC_BITS + 4;
  localparam logic signed [PW-1:0] RND     = PW'(1) << (59 - FRAC_BITS);
  localparam logic signed [RW-1:0] ONE     = RW'(1) << FRAC_BITS;
  localparam logic signed [RW-1:0] NEG_ONE = -ONE;

  function automatic logic signed [FRAC_BITS+1:0] finish(input logic signed [PW-1:0] s);
    logic signed [PW-1:0] t;
    logic signed [RW-1:0] r;
    t = s + RND;
    r = t[PW-1:60-FRAC_BITS];
    priority if (r > ONE) begin
      finish = ONE[FRAC_BITS+1:0];
    end else if (r < NEG_ONE) begin
      finish = NEG_ONE[FRAC_BITS+1:0];
    end else begin
      finish = r[FRAC_BITS+1:0];
    end
  endfunction

  logic                        va_r;
  logic                        vb_r;
  logic                        b_ready;
  logic signed [PW-1:0]        prod_r [8];
  logic signed [FRAC_BITS+1:0] w_r, x_r, y_r, z_r;

  assign b_ready  = !vb_r || dn_ready;
  assign up_ready = !va_r || b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (up_ready) begin
        va_r <= up_valid;
      end
      if (b_ready) begin
        vb_r <= va_r;
      end
    end
  end

  // triple products
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r[0] <= up_data.cr * up_data.pc;
      prod_r[1] <= up_data.sr * up_data.ps;
      prod_r[2] <= up_data.sr * up_data.pc;
      prod_r[3] <= up_data.cr * up_data.ps;
      prod_r[4] <= up_data.cr * up_data.psc;
      prod_r[5] <= up_data.sr * up_data.pcs;
      prod_r[6] <= up_data.cr * up_data.pcs;
      prod_r[7] <= up_data.sr * up_data.psc;
    end
  end

  // sums, rounding and saturation
  always_ff @(posedge clk) begin
    if (b_ready && va_r) begin
      w_r <= finish(prod_r[0] + prod_r[1]);
      x_r <= finish(prod_r[2] - prod_r[3]);
      y_r <= finish(prod_r[4] + prod_r[5]);
      z_r <= finish(prod_r[6] - prod_r[7]);
    end
  end

  assign dn_valid = vb_r;
  assign dn_w     = w_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_z     = z_r;

endmodule

`default_nettype wire

[hdl/euler_to_quaternion_core.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// ZYX Euler angles (binary angles) to a unit quaternion in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one request per clock while the sink keeps taking results, and
// returns one quaternion per request, in order. Each request passes through
// a register in every CORDIC cell of the rotation chain, then the pitch/yaw
// pair product register, the roll product register and the rounding output
// register. Every stage has its own valid bit, so bubbles close up and new
// requests are taken while a finished result waits for the sink. Outputs
// carry FRAC_BITS fractional bits, rounded to nearest and clamped to +-1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion_core #(
  parameter int ANGLE_BITS  = 16,
  parameter int FRAC_BITS   = 16,
  parameter int TRIG_STAGES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  e2q_in_if.sink   in_req,
  e2q_out_if.source out_req
);

  localparam int NCELL = (TRIG_STAGES < e2q_pkg::ATAN_ENTRIES) ?
                         TRIG_STAGES : e2q_pkg::ATAN_ENTRIES;
  localparam int PH_SH = 31 - ANGLE_BITS;

  logic           c_valid [NCELL+1];
  logic           c_ready [NCELL+1];
  e2q_pkg::rot3_t c_data  [NCELL+1];

  logic           m_valid;
  logic           m_ready;
  e2q_pkg::mix_t  m_data;

  // half angle phase, 2^31 = pi
  always_comb begin
    c_data[0][0].x = e2q_pkg::INV_GAIN;
    c_data[0][0].y = '0;
    c_data[0][0].z = {in_req.yaw_angle[ANGLE_BITS-1], in_req.yaw_angle, {PH_SH{1'b0}}};
    c_data[0][1].x = e2q_pkg::INV_GAIN;
    c_data[0][1].y = '0;
    c_data[0][1].z = {in_req.pitch_angle[ANGLE_BITS-1], in_req.pitch_angle,
                      {PH_SH{1'b0}}};
    c_data[0][2].x = e2q_pkg::INV_GAIN;
    c_data[0][2].y = '0;
    c_data[0][2].z = {in_req.roll_angle[ANGLE_BITS-1], in_req.roll_angle,
                      {PH_SH{1'b0}}};
  end

  assign c_valid[0]   = in_req.valid;
  assign in_req.ready = c_ready[0];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    e2q_cell #(
      .STAGE (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[g]),
      .up_ready (c_ready[g]),
      .up_data  (c_data[g]),
      .dn_valid (c_valid[g+1]),
      .dn_ready (c_ready[g+1]),
      .dn_data  (c_data[g+1])
    );
  end

  e2q_pair u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid[NCELL]),
    .up_ready (c_ready[NCELL]),
    .up_data  (c_data[NCELL]),
    .dn_valid (m_valid),
    .dn_ready (m_ready),
    .dn_data  (m_data)
  );

  e2q_quat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_quat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (m_valid),
    .up_ready (m_ready),
    .up_data  (m_data),
    .dn_valid (out_req.valid),
    .dn_ready (out_req.ready),
    .dn_w     (out_req.quat_w),
    .dn_x     (out_req.quat_x),
    .dn_y     (out_req.quat_y),
    .dn_z     (out_req.quat_z)
  );

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Euler angle to quaternion core.
// A directed table of corner angles runs first. Random angle triples follow
// under three idle profiles on the request and result sides. A sink hold-off
// backs up the pipeline in the last profile. Every quaternion field is compared
// with a bit-exact CORDIC and fixed-point predictor or a typed corner part.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int TRIG_STAGES  = 16;
  localparam int OUT_BITS     = FRAC_BITS + 2;
  localparam int PIPE_LATENCY = TRIG_STAGES + 3;
  localparam int DIRECTED_N   = 21;
  localparam int RANDOM_N     = 430;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_CAP    = 40;
  localparam int unsigned CYCLE_LIMIT = 100000;

  localparam longint CORDIC_START = 64'sd652032874;
  localparam longint FULL_SCALE   = longint'(1) << FRAC_BITS;

  localparam logic [3:0] MASK_NONE = 4'b0000;
  localparam logic [3:0] MASK_W    = 4'b1000;
  localparam logic [3:0] MASK_X    = 4'b0100;
  localparam logic [3:0] MASK_Y    = 4'b0010;
  localparam logic [3:0] MASK_Z    = 4'b0001;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [OUT_BITS-1:0]   qpart_t;

  typedef struct packed {
    qpart_t w;
    qpart_t x;
    qpart_t y;
    qpart_t z;
  } quat_t;

  typedef struct packed {
    angle_t     yaw;
    angle_t     pitch;
    angle_t     roll;
    logic [3:0] mask;
    quat_t      typed;
  } angle_row_t;

  logic clk;
  logic rst_n;

  e2q_in_if  #(.ANGLE_BITS(ANGLE_BITS)) in_ch ();
  e2q_out_if #(.FRAC_BITS(FRAC_BITS))   out_ch ();

  euler_to_quaternion_core #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .TRIG_STAGES(TRIG_STAGES)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_req(out_ch)
  );

  quat_t       quat_expect_q[$];
  logic [3:0]  cur_mask;
  quat_t       cur_typed;
  int          src_idle_pct;
  int          snk_idle_pct;
  bit          hold_req;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned clamp_count;
  int unsigned stall_cycles;

  // atan(2^-i), 2^31 = pi
  function automatic longint arctan_step(int i);
    case (i)
      0:       return 64'sh20000000;
      1:       return 64'sh12E4051E;
      2:       return 64'sh09FB385B;
      3:       return 64'sh051111D4;
      4:       return 64'sh028B0D43;
      5:       return 64'sh0145D7E1;
      6:       return 64'sh00A2F61E;
      7:       return 64'sh00517C55;
      8:       return 64'sh0028BE53;
      9:       return 64'sh00145F2F;
      10:      return 64'sh000A2F98;
      11:      return 64'sh000517CC;
      12:      return 64'sh00028BE6;
      13:      return 64'sh000145F3;
      14:      return 64'sh0000A2FA;
      15:      return 64'sh0000517D;
      16:      return 64'sh000028BE;
      17:      return 64'sh0000145F;
      18:      return 64'sh00000A30;
      19:      return 64'sh00000518;
      20:      return 64'sh0000028C;
      21:      return 64'sh00000146;
      22:      return 64'sh000000A3;
      23:      return 64'sh00000051;
      24:      return 64'sh00000029;
      25:      return 64'sh00000014;
      26:      return 64'sh0000000A;
      27:      return 64'sh00000005;
      28:      return 64'sh00000003;
      29:      return 64'sh00000001;
      default: return 64'sh0;
    endcase
  endfunction

  // cosine and sine of half the angle, Q30
  function automatic void half_angle_trig(input angle_t a, output longint c,
                                          output longint s);
    longint px, py, pz, dx, dy;
    px = CORDIC_START;
    py = 0;
    pz = longint'(a) * (longint'(1) << (31 - ANGLE_BITS));
    for (int i = 0; i < TRIG_STAGES && i < 30; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (pz >= 0) begin
        px = px - dx;
        py = py + dy;
        pz = pz - arctan_step(i);
      end else begin
        px = px + dx;
        py = py - dy;
        pz = pz + arctan_step(i);
      end
    end
    c = px;
    s = py;
  endfunction

  function automatic longint mul_round30(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic qpart_t to_frac(longint sum);
    longint r;
    r = (sum + (longint'(1) << (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
    if (r > FULL_SCALE) r = FULL_SCALE;
    if (r < -FULL_SCALE) r = -FULL_SCALE;
    return r[OUT_BITS-1:0];
  endfunction

  function automatic quat_t quat_from_euler(angle_t yaw, angle_t pitch, angle_t roll);
    longint cy, sy, cp, sp, cr, sr;
    longint pc, ps, pcs, psc;
    quat_t  q;
    half_angle_trig(yaw, cy, sy);
    half_angle_trig(pitch, cp, sp);
    half_angle_trig(roll, cr, sr);
    pc  = mul_round30(cp, cy);
    ps  = mul_round30(sp, sy);
    pcs = mul_round30(cp, sy);
    psc = mul_round30(sp, cy);
    q.w = to_frac(cr * pc + sr * ps);
    q.x = to_frac(sr * pc - cr * ps);
    q.y = to_frac(cr * psc + sr * pcs);
    q.z = to_frac(cr * pcs - sr * psc);
    return q;
  endfunction

  function automatic angle_row_t mk_row(int yaw, int pitch, int roll, logic [3:0] mask,
                                        int tw, int tx, int ty, int tz);
    angle_row_t r;
    r.yaw     = angle_t'(yaw);
    r.pitch   = angle_t'(pitch);
    r.roll    = angle_t'(roll);
    r.mask    = mask;
    r.typed.w = qpart_t'(tw);
    r.typed.x = qpart_t'(tx);
    r.typed.y = qpart_t'(ty);
    r.typed.z = qpart_t'(tz);
    return r;
  endfunction

  // corner angles, with typed parts where a part clamps to +-1.0
  function automatic angle_row_t directed_row(int idx);
    case (idx)
      0:       return mk_row(0, 0, 0, MASK_W, 65536, 0, 0, 0);
      1:       return mk_row(-32768, 0, 0, MASK_Z, 0, 0, 0, -65536);
      2:       return mk_row(0, -32768, 0, MASK_Y, 0, 0, -65536, 0);
      3:       return mk_row(0, 0, -32768, MASK_X, 0, -65536, 0, 0);
      4:       return mk_row(-32768, -32768, -32768, MASK_W, -65536, 0, 0, 0);
      5:       return mk_row(32767, 0, 0, MASK_Z, 0, 0, 0, 65536);
      6:       return mk_row(0, 32767, 0, MASK_Y, 0, 0, 65536, 0);
      7:       return mk_row(0, 0, 32767, MASK_X, 0, 65536, 0, 0);
      8:       return mk_row(32767, 32767, 32767, MASK_W, 65536, 0, 0, 0);
      9:       return mk_row(16384, 16384, 16384, MASK_NONE, 0, 0, 0, 0);
      10:      return mk_row(-16384, -16384, -16384, MASK_NONE, 0, 0, 0, 0);
      11:      return mk_row(16384, -16384, 16384, MASK_NONE, 0, 0, 0, 0);
      12:      return mk_row(1, -1, 1, MASK_NONE, 0, 0, 0, 0);
      13:      return mk_row(-1, 1, -1, MASK_NONE, 0, 0, 0, 0);
      14:      return mk_row(21845, -21846, 21845, MASK_NONE, 0, 0, 0, 0);
      15:      return mk_row(-21846, 21845, -21846, MASK_NONE, 0, 0, 0, 0);
      16:      return mk_row(255, -256, 255, MASK_NONE, 0, 0, 0, 0);
      17:      return mk_row(-32768, 32767, 0, MASK_NONE, 0, 0, 0, 0);
      18:      return mk_row(32767, -32768, 12345, MASK_NONE, 0, 0, 0, 0);
      19:      return mk_row(8192, -8192, 24576, MASK_NONE, 0, 0, 0, 0);
      default: return mk_row(-24576, 30000, -30000, MASK_NONE, 0, 0, 0, 0);
    endcase
  endfunction

  // mostly uniform, some close to 0, +-pi/2 and +-pi
  function automatic angle_t pick_angle();
    int base;
    if ($urandom_range(9) != 0) return angle_t'($urandom);
    case ($urandom_range(4))
      0:       base = -32768;
      1:       base = 32767;
      2:       base = 0;
      3:       base = 16384;
      default: base = -16384;
    endcase
    return angle_t'(base + int'($urandom_range(8)) - 4);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic offer_request(angle_t yaw, angle_t pitch, angle_t roll,
                               logic [3:0] mask, quat_t typed);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.yaw_angle   = yaw;
    in_ch.pitch_angle = pitch;
    in_ch.roll_angle  = roll;
    cur_mask          = mask;
    cur_typed         = typed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic random_requests(int count, int hold_at);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      offer_request(pick_angle(), pick_angle(), pick_angle(), MASK_NONE, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side
  initial begin : sink
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watch
    quat_t want;
    quat_t got;
    cycle_count++;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = quat_from_euler(in_ch.yaw_angle, in_ch.pitch_angle, in_ch.roll_angle);
        if (cur_mask & MASK_W) want.w = cur_typed.w;
        if (cur_mask & MASK_X) want.x = cur_typed.x;
        if (cur_mask & MASK_Y) want.y = cur_typed.y;
        if (cur_mask & MASK_Z) want.z = cur_typed.z;
        quat_expect_q.push_back(want);
        sent_count++;
      end
      if (in_ch.valid && !in_ch.ready) stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z};
        if (quat_expect_q.size() == 0) begin
          report_mismatch($sformatf("quaternion %0d/%0d/%0d/%0d with no request pending",
                                    got.w, got.x, got.y, got.z));
        end else begin
          want = quat_expect_q.pop_front();
          if (got.w !== want.w)
            report_mismatch($sformatf("result %0d quat_w %0d, expected %0d",
                                      checked_count, got.w, want.w));
          if (got.x !== want.x)
            report_mismatch($sformatf("result %0d quat_x %0d, expected %0d",
                                      checked_count, got.x, want.x));
          if (got.y !== want.y)
            report_mismatch($sformatf("result %0d quat_y %0d, expected %0d",
                                      checked_count, got.y, want.y));
          if (got.z !== want.z)
            report_mismatch($sformatf("result %0d quat_z %0d, expected %0d",
                                      checked_count, got.z, want.z));
          if ((want.w == FULL_SCALE) || (want.w == -FULL_SCALE) ||
              (want.x == FULL_SCALE) || (want.x == -FULL_SCALE) ||
              (want.y == FULL_SCALE) || (want.y == -FULL_SCALE) ||
              (want.z == FULL_SCALE) || (want.z == -FULL_SCALE))
            clamp_count++;
          checked_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, quat_expect_q.size());
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    angle_row_t row;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.yaw_angle   = '0;
    in_ch.pitch_angle = '0;
    in_ch.roll_angle  = '0;
    cur_mask          = MASK_NONE;
    cur_typed         = '0;
    src_idle_pct      = 0;
    snk_idle_pct      = 0;
    hold_req          = 1'b0;
    cycle_count       = 0;
    mismatch_count    = 0;
    sent_count        = 0;
    checked_count     = 0;
    clamp_count       = 0;
    stall_cycles      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner table
    for (int i = 0; i < DIRECTED_N; i++) begin
      row = directed_row(i);
      offer_request(row.yaw, row.pitch, row.roll, row.mask, row.typed);
    end

    // sender pauses until the pipeline is empty
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (quat_expect_q.size() != 0) @(posedge clk);

    src_idle_pct = 11;
    snk_idle_pct = 74;
    random_requests(RANDOM_N, -1);
    src_idle_pct = 74;
    snk_idle_pct = 11;
    random_requests(RANDOM_N, -1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_requests(RANDOM_N, 120);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (quat_expect_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("summary: %0d angle triples (%0d corner rows) in, %0d quaternions checked,",
             sent_count, DIRECTED_N, checked_count);
    $display("summary: %0d at +-1.0, %0d request cycles stalled by back-pressure",
             clamp_count, stall_cycles);
    if (mismatch_count == 0 && quat_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[euler_to_quaternion_core.f]
hdl/e2q_pkg.sv
hdl/e2q_in_if.sv
hdl/e2q_out_if.sv
hdl/e2q_cell.sv
hdl/e2q_pair.sv
hdl/e2q_quat.sv
hdl/euler_to_quaternion_core.sv
verif/tb_top.sv
